// ===== hdl/pias_pkg.sv =====
// ----------------------------------------------------------------------------
// pias_pkg
// Shared types and constants for the iris polar sampling address generator.
// ----------------------------------------------------------------------------
package pias_pkg;

  localparam int COL_OUT_W = 13;
  localparam int ROW_OUT_W = 11;
  localparam int SRC_W     = 14;
  localparam int RAD_W     = 10;
  localparam int IMG_W     = 13;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // 2*pi in Q32 and pi/2 in Q30
  localparam longint unsigned TWO_PI_Q32  = 64'd26986075409;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_PUPIL_CX  = 3'd0,
    REG_PUPIL_CY  = 3'd1,
    REG_PUPIL_R   = 3'd2,
    REG_LIMBUS_CX = 3'd3,
    REG_LIMBUS_CY = 3'd4,
    REG_LIMBUS_R  = 3'd5,
    REG_IMG_W     = 3'd6,
    REG_IMG_H     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       sheet_start;
    logic       size_step;
    logic       trig_start;
    logic       trig_latch;
    logic       quarter;
    logic       pt_step;
    logic [1:0] pt_sel;
    logic       mul_a;
    logic       mul_b;
    logic       axis;
    logic       samp_start;
    logic       samp_latch;
    logic       result;
    logic       push;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic size_done;
    logic need_sheet;
    logic row_wrap;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/polar_iris_sampling_addresses_top.sv =====
// ----------------------------------------------------------------------------
// polar_iris_sampling_addresses_top
// Source pixel addresses for a rubber-sheet unwrap of the iris.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | restart
//  out      | out_valid / out_ready | polar_col polar_row source_x source_y
//           |                       | in_image sheet_last
//  config   | psel penable pwrite   | paddr pwdata prdata (pready tied high)
//
//  One transaction at a time. Each sample takes two passes through the
//  shared bit-serial divider, one per axis (QW = 14 at default parameters).
//  A sample that ends a column also loads the next column; a restart also
//  sizes the sheet and loads its first column.
//  Reset is synchronous; no clearing pass. A result waits in the output
//  register while the next transaction is taken in.
module polar_iris_sampling_addresses_top #(
  parameter int SINE_ENTRIES = 1024,
  parameter int COORD_BITS   = 12,
  parameter int MAX_RADIUS   = 1023
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pias_pkg::ADDR_W-1:0]        paddr,
  input  logic [pias_pkg::DATA_W-1:0]        pwdata,
  output logic [pias_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pias_pkg::COL_OUT_W-1:0]     polar_col,
  output logic [pias_pkg::ROW_OUT_W-1:0]     polar_row,
  output logic signed [pias_pkg::SRC_W-1:0]  source_x,
  output logic signed [pias_pkg::SRC_W-1:0]  source_y,
  output logic                               in_image,
  output logic                               sheet_last
);

  localparam int RAD_W = pias_pkg::RAD_W;
  localparam int IMG_W = pias_pkg::IMG_W;

  logic [COORD_BITS-1:0] pcx, pcy, lcx, lcy;
  logic [RAD_W-1:0]      pr, lr;
  logic [IMG_W-1:0]      img_w, img_h;
  logic                  wr_en;
  pias_pkg::reg_idx_t    widx;
  pias_pkg::dp_cmd_t     cmd;
  pias_pkg::dp_stat_t    stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = pias_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pcx   <= '0;
      pcy   <= '0;
      pr    <= '0;
      lcx   <= '0;
      lcy   <= '0;
      lr    <= RAD_W'(1);
      img_w <= IMG_W'(640);
      img_h <= IMG_W'(480);
    end else if (wr_en) begin
      case (widx)
        pias_pkg::REG_PUPIL_CX:  pcx   <= pwdata[COORD_BITS-1:0];
        pias_pkg::REG_PUPIL_CY:  pcy   <= pwdata[COORD_BITS-1:0];
        pias_pkg::REG_PUPIL_R:   pr    <= pwdata[RAD_W-1:0];
        pias_pkg::REG_LIMBUS_CX: lcx   <= pwdata[COORD_BITS-1:0];
        pias_pkg::REG_LIMBUS_CY: lcy   <= pwdata[COORD_BITS-1:0];
        pias_pkg::REG_LIMBUS_R:  lr    <= pwdata[RAD_W-1:0];
        pias_pkg::REG_IMG_W:     img_w <= pwdata[IMG_W-1:0];
        pias_pkg::REG_IMG_H:     img_h <= pwdata[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      pias_pkg::REG_PUPIL_CX:  prdata = pias_pkg::DATA_W'(pcx);
      pias_pkg::REG_PUPIL_CY:  prdata = pias_pkg::DATA_W'(pcy);
      pias_pkg::REG_PUPIL_R:   prdata = pias_pkg::DATA_W'(pr);
      pias_pkg::REG_LIMBUS_CX: prdata = pias_pkg::DATA_W'(lcx);
      pias_pkg::REG_LIMBUS_CY: prdata = pias_pkg::DATA_W'(lcy);
      pias_pkg::REG_LIMBUS_R:  prdata = pias_pkg::DATA_W'(lr);
      pias_pkg::REG_IMG_W:     prdata = pias_pkg::DATA_W'(img_w);
      pias_pkg::REG_IMG_H:     prdata = pias_pkg::DATA_W'(img_h);
      default:                 prdata = '0;
    endcase
  end

  pias_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pias_dp #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .COORD_BITS   (COORD_BITS),
    .MAX_RADIUS   (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .pcx        (pcx),
    .pcy        (pcy),
    .pr         (pr),
    .lcx        (lcx),
    .lcy        (lcy),
    .lr         (lr),
    .img_w      (img_w),
    .img_h      (img_h),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .polar_col  (polar_col),
    .polar_row  (polar_row),
    .source_x   (source_x),
    .source_y   (source_y),
    .in_image   (in_image),
    .sheet_last (sheet_last)
  );

endmodule

// ===== hdl/pias_div.sv =====
// ----------------------------------------------------------------------------
// pias_div
// Restoring divider, one quotient bit per cycle, shared by angle and sample.
// ----------------------------------------------------------------------------
module pias_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int XW  = (NW > DW + QW) ? NW : DW + QW;
  localparam int CNW = $clog2(QW + 1);

  logic [XW-1:0]  rem;
  logic [XW-1:0]  dsh;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic           fit;

  // quotient is known to fit QW bits, so the divisor starts at its top bit
  assign fit = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNW'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= XW'(num);
      dsh <= XW'(den) << (QW - 1);
      cnt <= '0;
    end else if (busy) begin
      if (fit) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QW-2:0], fit};
      dsh <= dsh >> 1;
      cnt <= cnt + CNW'(1);
    end
  end

endmodule

// ===== hdl/pias_dp.sv =====
// ----------------------------------------------------------------------------
// pias_dp
// Datapath: sheet size, column trig, circle points, sample interpolation.
// ----------------------------------------------------------------------------
module pias_dp #(
  parameter int SINE_ENTRIES = 1024,
  parameter int COORD_BITS   = 12,
  parameter int MAX_RADIUS   = 1023
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pias_pkg::dp_cmd_t              cmd,
  output pias_pkg::dp_stat_t             stat,
  input  logic [COORD_BITS-1:0]          pcx,
  input  logic [COORD_BITS-1:0]          pcy,
  input  logic [pias_pkg::RAD_W-1:0]     pr,
  input  logic [COORD_BITS-1:0]          lcx,
  input  logic [COORD_BITS-1:0]          lcy,
  input  logic [pias_pkg::RAD_W-1:0]     lr,
  input  logic [pias_pkg::IMG_W-1:0]     img_w,
  input  logic [pias_pkg::IMG_W-1:0]     img_h,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [pias_pkg::COL_OUT_W-1:0] polar_col,
  output logic [pias_pkg::ROW_OUT_W-1:0] polar_row,
  output logic signed [pias_pkg::SRC_W-1:0] source_x,
  output logic signed [pias_pkg::SRC_W-1:0] source_y,
  output logic                           in_image,
  output logic                           sheet_last
);

  localparam int RAD_W = pias_pkg::RAD_W;
  localparam int RMAX  = (MAX_RADIUS < 1023) ? MAX_RADIUS : 1023;
  localparam longint unsigned CMAX =
    (longint'(RMAX) * pias_pkg::TWO_PI_Q32 + 64'd2147483648) >> 32;
  localparam int CCW  = $clog2(CMAX + 1);
  localparam int RCW  = $clog2(2 * RMAX + 1);
  localparam int SEW  = $clog2(SINE_ENTRIES + 1);
  localparam int TIW  = $clog2(SINE_ENTRIES);
  localparam int PTW  = ((COORD_BITS > 10) ? COORD_BITS + 10 : 20) + 2;
  localparam int PRW  = PTW + RCW + 1;
  localparam int NUMW = PRW + 1;
  localparam int SNW  = NUMW - 9;
  localparam int TNW  = CCW + SEW + 5;
  localparam int NW   = (SNW > TNW) ? SNW : TNW;
  localparam int DW   = (CCW + 3 > RCW) ? CCW + 3 : RCW;
  localparam int QW   = (SEW + 1 > PTW - 10) ? SEW + 1 : PTW - 10;
  localparam int SXW  = QW + 1;
  localparam int ACCW = 35 + RAD_W;
  localparam int SCW  = $clog2(RAD_W);
  localparam int RTW  = RAD_W + 17;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];
  localparam longint unsigned SERIES_DIV [8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  function automatic logic signed [15:0] sine_entry(input longint unsigned k);
    longint unsigned u, x, x2, term;
    longint          sum;
    logic            neg;
    u   = (((k << 33) + longint'(SINE_ENTRIES)) / (2 * SINE_ENTRIES)) & 64'hFFFF_FFFF;
    neg = 1'b0;
    if (u >= (64'd1 << 31)) begin
      neg = 1'b1;
      u   = u - (64'd1 << 31);
    end
    if (u > (64'd1 << 30)) begin
      u = (64'd1 << 31) - u;
    end
    x    = (u * pias_pkg::HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) / 32768;
    if (sum > 32767) begin
      sum = 32767;
    end
    return neg ? 16'(-sum) : 16'(sum);
  endfunction

  function automatic sine_tab_t build_tab();
    sine_tab_t t;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t[k] = sine_entry(longint'(k));
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  // sheet walk state
  logic [RAD_W-1:0] rad;
  logic [ACCW-1:0]  acc, acc_next;
  logic [SCW-1:0]   scnt;
  logic [CCW-1:0]   col, cc;
  logic [RCW-1:0]   row, rc;

  // column trig and circle points
  logic signed [15:0]    cosv, sinv, tv;
  logic signed [PTW-1:0] lpx, lpy, ppx, ppy, pt_val;
  logic [COORD_BITS-1:0] sel_c;
  logic [RAD_W-1:0]      sel_r;
  logic signed [15:0]    sel_t;
  logic signed [RTW-1:0] rt;

  // sample interpolation
  logic signed [PRW-1:0]  pa, pb;
  logic signed [NUMW-1:0] ssum;
  logic [NUMW-1:0]        smag;
  logic [NUMW:0]          sadd;
  logic                   samp_neg;
  logic signed [SXW-1:0]  sx, sy, sval;

  // angle index
  logic [CCW+2:0] tbase;
  logic [TNW-1:0] tnum;
  logic [QW-1:0]  quo, tidx;

  // divider
  logic [NW-1:0] dnum;
  logic [DW-1:0] dden;
  logic          ddone;

  // result hold
  logic [pias_pkg::COL_OUT_W-1:0]   h_col;
  logic [pias_pkg::ROW_OUT_W-1:0]   h_row;
  logic signed [pias_pkg::SRC_W-1:0] h_sx, h_sy;
  logic                             h_in, h_last;
  logic                             row_end, col_end;

  assign acc_next = rad[scnt] ? acc + (ACCW'(pias_pkg::TWO_PI_Q32) << scnt) : acc;
  assign row_end  = row == rc - RCW'(1);
  assign col_end  = col == cc - CCW'(1);

  // angle: round(S*(q*w + 4c) / 4w), numerator and divisor both doubled
  assign tbase = (cmd.quarter ? (CCW+3)'(cc) : '0) + {col, 2'b00};
  assign tnum  = ((TNW'(tbase) * TNW'(SINE_ENTRIES)) << 1) + (TNW'(cc) << 2);
  assign tidx  = (quo >= QW'(SINE_ENTRIES)) ? quo - QW'(SINE_ENTRIES) : quo;
  assign tv    = SINE_TAB[tidx[TIW-1:0]];

  // round half away from zero: |n|/(1024 rc) after adding 512 rc
  assign ssum = NUMW'(pa) + NUMW'(pb);
  assign smag = ssum[NUMW-1] ? NUMW'(-ssum) : NUMW'(ssum);
  assign sadd = (NUMW+1)'(smag) + ((NUMW+1)'(rc) << 9);

  assign dnum = cmd.samp_start ? NW'(sadd[NUMW:10]) : NW'(tnum);
  assign dden = cmd.samp_start ? DW'(rc) : DW'((CCW+3)'(cc) << 3);

  pias_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.trig_start | cmd.samp_start),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (quo)
  );

  always_comb begin
    case (cmd.pt_sel)
      2'd0:    begin sel_c = lcx; sel_r = lr; sel_t = cosv; end
      2'd1:    begin sel_c = lcy; sel_r = lr; sel_t = sinv; end
      2'd2:    begin sel_c = pcx; sel_r = pr; sel_t = cosv; end
      default: begin sel_c = pcy; sel_r = pr; sel_t = sinv; end
    endcase
  end

  assign rt     = $signed({1'b0, sel_r}) * sel_t;
  assign pt_val = $signed(PTW'({sel_c, 10'b0})) + PTW'((rt + RTW'(16)) >>> 5);
  assign sval   = samp_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      cc  <= '0;
      rc  <= '0;
      col <= '0;
      row <= '0;
    end else if (cmd.sheet_start) begin
      col <= '0;
      row <= '0;
    end else if (cmd.size_step && stat.size_done) begin
      if (rad == '0) begin
        cc <= CCW'(1);
        rc <= RCW'(1);
      end else begin
        cc <= acc_next[32 +: CCW] + CCW'(acc_next[31]);
        rc <= RCW'({rad, 1'b0});
      end
    end else if (cmd.result) begin
      if (row_end) begin
        row <= '0;
        col <= col_end ? '0 : col + CCW'(1);
      end else begin
        row <= row + RCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sheet_start) begin
      rad  <= (lr > RAD_W'(RMAX)) ? RAD_W'(RMAX) : lr;
      acc  <= '0;
      scnt <= '0;
    end else if (cmd.size_step) begin
      acc  <= acc_next;
      scnt <= scnt + SCW'(1);
    end
    if (cmd.trig_latch) begin
      if (cmd.quarter) begin
        sinv <= -tv;
      end else begin
        cosv <= tv;
      end
    end
    if (cmd.pt_step) begin
      case (cmd.pt_sel)
        2'd0:    lpx <= pt_val;
        2'd1:    lpy <= pt_val;
        2'd2:    ppx <= pt_val;
        default: ppy <= pt_val;
      endcase
    end
    if (cmd.mul_a) begin
      pa <= $signed({1'b0, rc - row}) * (cmd.axis ? lpy : lpx);
    end
    if (cmd.mul_b) begin
      pb <= $signed({1'b0, row}) * (cmd.axis ? ppy : ppx);
    end
    if (cmd.samp_start) begin
      samp_neg <= ssum[NUMW-1];
    end
    if (cmd.samp_latch) begin
      if (cmd.axis) begin
        sy <= sval;
      end else begin
        sx <= sval;
      end
    end
    if (cmd.result) begin
      h_col  <= pias_pkg::COL_OUT_W'(col);
      h_row  <= pias_pkg::ROW_OUT_W'(row);
      h_sx   <= pias_pkg::SRC_W'(sx);
      h_sy   <= pias_pkg::SRC_W'(sy);
      h_in   <= sx >= 0 && sy >= 0 && sx < $signed({1'b0, img_w}) &&
                sy < $signed({1'b0, img_h});
      h_last <= col_end && row_end;
    end
    if (cmd.push) begin
      polar_col  <= h_col;
      polar_row  <= h_row;
      source_x   <= h_sx;
      source_y   <= h_sy;
      in_image   <= h_in;
      sheet_last <= h_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.div_done   = ddone;
  assign stat.size_done  = scnt == SCW'(RAD_W - 1);
  assign stat.need_sheet = cc == '0;
  assign stat.row_wrap   = row_end;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== hdl/pias_ctrl.sv =====
// ----------------------------------------------------------------------------
// pias_ctrl
// Sequencer: sheet setup, column load, two-axis sample, result hand-off.
// ----------------------------------------------------------------------------
module pias_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                restart,
  output logic                in_ready,
  input  pias_pkg::dp_stat_t  stat,
  output pias_pkg::dp_cmd_t   cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SIZE   = 10'b00_0000_0010,
    ST_TRIG   = 10'b00_0000_0100,
    ST_TWAIT  = 10'b00_0000_1000,
    ST_PTS    = 10'b00_0001_0000,
    ST_MUL    = 10'b00_0010_0000,
    ST_SSTART = 10'b00_0100_0000,
    ST_SWAIT  = 10'b00_1000_0000,
    ST_RES    = 10'b01_0000_0000,
    ST_PUSH   = 10'b10_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] sub, sub_next;
  logic       quarter, quarter_next;
  logic       axis, axis_next;
  logic       post, post_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    sub_next     = sub;
    quarter_next = quarter;
    axis_next    = axis;
    post_next    = post;
    cmd.quarter  = quarter;
    cmd.axis     = axis;
    cmd.pt_sel   = sub;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          post_next = 1'b0;
          axis_next = 1'b0;
          sub_next  = '0;
          if (restart || stat.need_sheet) begin
            cmd.sheet_start = 1'b1;
            state_next      = ST_SIZE;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_SIZE: begin
        cmd.size_step = 1'b1;
        if (stat.size_done) begin
          quarter_next = 1'b0;
          state_next   = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd.trig_start = 1'b1;
        state_next     = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (stat.div_done) begin
          cmd.trig_latch = 1'b1;
          if (!quarter) begin
            quarter_next = 1'b1;
            state_next   = ST_TRIG;
          end else begin
            sub_next   = '0;
            state_next = ST_PTS;
          end
        end
      end
      ST_PTS: begin
        cmd.pt_step = 1'b1;
        sub_next    = sub + 2'd1;
        if (sub == 2'd3) begin
          axis_next  = 1'b0;
          state_next = post ? ST_PUSH : ST_MUL;
        end
      end
      ST_MUL: begin
        if (!sub[0]) begin
          cmd.mul_a = 1'b1;
          sub_next  = 2'd1;
        end else begin
          cmd.mul_b  = 1'b1;
          sub_next   = '0;
          state_next = ST_SSTART;
        end
      end
      ST_SSTART: begin
        cmd.samp_start = 1'b1;
        state_next     = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (stat.div_done) begin
          cmd.samp_latch = 1'b1;
          if (!axis) begin
            axis_next  = 1'b1;
            state_next = ST_MUL;
          end else begin
            state_next = ST_RES;
          end
        end
      end
      ST_RES: begin
        cmd.result = 1'b1;
        // the next column is loaded before the result leaves
        if (stat.row_wrap) begin
          post_next    = 1'b1;
          quarter_next = 1'b0;
          state_next   = ST_TRIG;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sub     <= '0;
      quarter <= 1'b0;
      axis    <= 1'b0;
      post    <= 1'b0;
    end else begin
      state   <= state_next;
      sub     <= sub_next;
      quarter <= quarter_next;
      axis    <= axis_next;
      post    <= post_next;
    end
  end

endmodule

// ===== hdl/pias_chk.sv =====
// ----------------------------------------------------------------------------
// pias_chk
// Port-level checks for the polar sampling address generator.
// ----------------------------------------------------------------------------
module pias_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pias_pkg::COL_OUT_W-1:0]     polar_col,
  input logic [pias_pkg::ROW_OUT_W-1:0]     polar_row
);

  // a held result keeps its position
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(polar_col) && $stable(polar_row))
    else $error("output transaction changed while stalled");

  // one transaction in flight: the block is busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a new result only appears as the sequencer returns to idle
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result appeared outside the hand-off");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind polar_iris_sampling_addresses_top pias_chk u_pias_chk (.*);
